/* hdl/usfp_pkg.sv */
// shared types, constants and the frame layout table for the ups status frame parser
// no dependencies
package usfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned ACC_W       = 20;
  localparam int unsigned FRAC_W      = 2;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned ID_W        = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned FIELD_COUNT = 22;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h28;
  localparam logic [BYTE_W-1:0] CR_BYTE     = 8'h0D;
  localparam logic [BYTE_W-1:0] POINT_BYTE  = 8'h2E;
  localparam logic [BYTE_W-1:0] SPACE_BYTE  = 8'h20;
  localparam logic [BYTE_W-1:0] FLAG_ONE    = 8'h31;
  localparam logic [BYTE_W-1:0] ZERO_CHAR   = 8'h30;
  localparam logic [POS_W-1:0]  END_POS     = 7'd109;
  localparam logic [ID_W-1:0]   END_ID      = 5'd22;
  localparam logic [FRAC_W-1:0] FRAC_MAX    = 2'd3;

  typedef enum logic [2:0] {
    KIND_TENTHS,
    KIND_INT,
    KIND_RAW,
    KIND_CODE,
    KIND_FLAG
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_HEADER,
    ST_NO_CR
  } status_e;

  typedef struct packed {
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    kind_e            kind;
  } field_desc_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] idx;
    logic            first;
    logic            last;
    kind_e           kind;
  } lookup_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic               last;
  } result_t;

  localparam field_desc_t FIELD_TBL [FIELD_COUNT] = '{
    '{7'd1,   7'd5,   KIND_TENTHS}, '{7'd7,   7'd11,  KIND_TENTHS},
    '{7'd13,  7'd17,  KIND_TENTHS}, '{7'd19,  7'd22,  KIND_TENTHS},
    '{7'd24,  7'd28,  KIND_TENTHS}, '{7'd30,  7'd34,  KIND_TENTHS},
    '{7'd36,  7'd40,  KIND_TENTHS}, '{7'd42,  7'd45,  KIND_TENTHS},
    '{7'd47,  7'd49,  KIND_INT},    '{7'd51,  7'd53,  KIND_INT},
    '{7'd55,  7'd57,  KIND_INT},
    '{7'd59,  7'd63,  KIND_TENTHS}, '{7'd65,  7'd69,  KIND_TENTHS},
    '{7'd71,  7'd74,  KIND_TENTHS},
    '{7'd76,  7'd80,  KIND_INT},    '{7'd82,  7'd84,  KIND_INT},
    '{7'd86,  7'd86,  KIND_RAW},    '{7'd87,  7'd87,  KIND_RAW},
    '{7'd89,  7'd96,  KIND_CODE},   '{7'd98,  7'd105, KIND_CODE},
    '{7'd107, 7'd107, KIND_FLAG},   '{7'd108, 7'd108, KIND_FLAG}
  };

  // which field a byte position belongs to, if any
  function automatic lookup_t field_lookup(input logic [POS_W-1:0] pos);
    lookup_t r;
    r = '{hit: 1'b0, idx: '0, first: 1'b0, last: 1'b0, kind: KIND_RAW};
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (pos >= FIELD_TBL[i].first && pos <= FIELD_TBL[i].last) begin
        r.hit   = 1'b1;
        r.idx   = ID_W'(i);
        r.first = (pos == FIELD_TBL[i].first);
        r.last  = (pos == FIELD_TBL[i].last);
        r.kind  = FIELD_TBL[i].kind;
      end
    end
    return r;
  endfunction

endpackage

/* hdl/usfp_parse.sv */
// frame walker: byte position, number and code assembly, one result per field
// depends on usfp_pkg
module usfp_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [usfp_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          start_i,
  output logic                          res_vld_o,
  output usfp_pkg::result_t             res_o
);
  import usfp_pkg::*;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic               abort_q, abort_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               pnt_q, pnt_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic               stop_q, stop_d;
  logic               dig_q, dig_d;
  logic [VALUE_W-1:0] code_q, code_d;

  logic               active;
  logic [POS_W-1:0]   pos_eff;
  lookup_t            look;
  logic [ACC_W-1:0]   acc_b, acc_n, acc_mac;
  logic               pnt_b, pnt_n, stop_b, stop_n, dig_b, dig_n;
  logic [FRAC_W-1:0]  frac_b, frac_n;
  logic [VALUE_W-1:0] code_b, code_n;
  logic               numeric, is_digit, is_blank;
  logic [ACC_W+3:0]   acc_x10;
  logic [VALUE_W-1:0] fld_val;

  always_comb begin
    active  = start_i || !abort_q;
    pos_eff = start_i ? '0 : pos_q;
    look    = field_lookup(pos_eff);

    // per-field state starts clean on the first byte of a field
    acc_b  = look.first ? '0 : acc_q;
    pnt_b  = look.first ? 1'b0 : pnt_q;
    frac_b = look.first ? '0 : frac_q;
    stop_b = look.first ? 1'b0 : stop_q;
    dig_b  = look.first ? 1'b0 : dig_q;
    code_b = look.first ? '0 : code_q;

    numeric  = (look.kind == KIND_TENTHS) || (look.kind == KIND_INT);
    is_digit = byte_i inside {[8'h30:8'h39]};
    is_blank = (byte_i == SPACE_BYTE) || (byte_i inside {[8'h09:8'h0D]});
    acc_mac  = {acc_b[ACC_W-4:0], 3'b000} + {acc_b[ACC_W-2:0], 1'b0}
             + ACC_W'(DIGIT_W'(byte_i - ZERO_CHAR));

    acc_n  = acc_b;
    pnt_n  = pnt_b;
    frac_n = frac_b;
    stop_n = stop_b;
    dig_n  = dig_b;
    if (numeric && !stop_b && !(!dig_b && is_blank)) begin
      if (is_digit) begin
        dig_n = 1'b1;
        if (pnt_b) begin
          if (frac_b == '0) begin
            acc_n  = acc_mac;
            frac_n = FRAC_W'(1);
          end else if (frac_b != FRAC_MAX) begin
            frac_n = frac_b + FRAC_W'(1);
          end
        end else begin
          acc_n = acc_mac;
        end
      end else if (byte_i == POINT_BYTE && look.kind == KIND_TENTHS && !pnt_b) begin
        pnt_n = 1'b1;
        dig_n = 1'b1;
      end else begin
        stop_n = 1'b1;
      end
    end

    code_n  = (look.kind == KIND_CODE) ? {code_b[VALUE_W-BYTE_W-1:0], byte_i} : code_b;
    acc_x10 = {1'b0, acc_n, 3'b000} + {3'b000, acc_n, 1'b0};

    case (look.kind)
      KIND_TENTHS: fld_val = (frac_n == '0) ? VALUE_W'(acc_x10) : VALUE_W'(acc_n);
      KIND_INT:    fld_val = VALUE_W'(acc_n);
      KIND_RAW:    fld_val = VALUE_W'(byte_i);
      KIND_CODE:   fld_val = code_n;
      KIND_FLAG:   fld_val = VALUE_W'(byte_i == FLAG_ONE);
      default:     fld_val = '0;
    endcase
  end

  always_comb begin
    pos_d     = pos_q;
    abort_d   = abort_q;
    acc_d     = acc_q;
    pnt_d     = pnt_q;
    frac_d    = frac_q;
    stop_d    = stop_q;
    dig_d     = dig_q;
    code_d    = code_q;
    res_vld_o = 1'b0;
    res_o     = '{id: END_ID, value: '0, status: ST_OK, last: 1'b1};

    if (step_i && active) begin
      abort_d = 1'b0;
      if (pos_eff == '0) begin
        if (byte_i != HEADER_BYTE) begin
          abort_d      = 1'b1;
          pos_d        = '0;
          res_vld_o    = 1'b1;
          res_o.status = ST_NO_HEADER;
        end else begin
          pos_d = POS_W'(1);
        end
      end else if (pos_eff >= END_POS) begin
        abort_d      = 1'b1;
        pos_d        = '0;
        res_vld_o    = 1'b1;
        res_o.status = (byte_i == CR_BYTE) ? ST_OK : ST_NO_CR;
      end else begin
        pos_d = pos_eff + POS_W'(1);
        if (look.hit) begin
          acc_d  = acc_n;
          pnt_d  = pnt_n;
          frac_d = frac_n;
          stop_d = stop_n;
          dig_d  = dig_n;
          code_d = code_n;
          if (look.last) begin
            res_vld_o = 1'b1;
            res_o     = '{id: look.idx, value: fld_val, status: ST_OK, last: 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      abort_q <= 1'b1;
      acc_q   <= '0;
      pnt_q   <= 1'b0;
      frac_q  <= '0;
      stop_q  <= 1'b0;
      dig_q   <= 1'b0;
      code_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      abort_q <= abort_d;
      acc_q   <= acc_d;
      pnt_q   <= pnt_d;
      frac_q  <= frac_d;
      stop_q  <= stop_d;
      dig_q   <= dig_d;
      code_q  <= code_d;
    end
  end

endmodule

/* hdl/ups_status_frame_parser.sv */
// top level of the ups status frame parser: input register, frame walker, result register
// depends on usfp_pkg and usfp_parse
//
// Takes the 110-byte ASCII status reply of a UPS one byte per request and gives one
// result request per completed field (ids 0-15 numeric, 16/17 mode and test bytes,
// 18/19 packed 8-byte codes, 20/21 Y and O flags) and a final end result (id 22,
// last set) whose status tells ok, missing '(' header or missing carriage return.
// A byte with frame_start set begins a new frame at any time; a frame cut short that
// way is dropped silently, and before the first frame start all bytes are ignored.
// Voltage, frequency and temperature come out in tenths; load, runtime and capacity
// as raw integers. One byte is taken every clock cycle while in_stall_o is low; a byte
// is held in the input register and its result in the result register. The rate is set
// by the walker step, which only needs a position table lookup and one multiply-by-ten
// accumulate.
module ups_status_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [usfp_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [usfp_pkg::ID_W-1:0]       field_id_o,
  output logic [usfp_pkg::VALUE_W-1:0]    field_value_o,
  output logic [usfp_pkg::STATUS_W-1:0]   status_o,
  output logic                            last_o
);
  import usfp_pkg::*;

  // input register
  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_start_q;

  // result register
  logic              out_vld_q, out_vld_d;
  result_t           out_res_q;

  logic              adv;
  logic              res_vld;
  result_t           res;

  // the walker steps when its result slot is free or being drained
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  usfp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_vld_q && adv),
    .byte_i   (in_byte_q),
    .start_i  (in_start_q),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    if (in_vld_q && adv && res_vld) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= rx_byte_i;
      in_start_q <= frame_start_i;
    end
    if (in_vld_q && adv && res_vld) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign field_id_o    = out_res_q.id;
  assign field_value_o = out_res_q.value;
  assign status_o      = out_res_q.status;
  assign last_o        = out_res_q.last;

endmodule

/* verif/ups_status_frame_parser_checker.sv */
`timescale 1ns / 100ps
// result checker for the ups status frame parser: mirrors the byte walker and compares results
// depends on usfp_pkg for widths, byte constants and the kind/status enums
module ups_status_frame_parser_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [usfp_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          frame_start_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [usfp_pkg::ID_W-1:0]     field_id_i,
  input  logic [usfp_pkg::VALUE_W-1:0]  field_value_i,
  input  logic [usfp_pkg::STATUS_W-1:0] status_i,
  input  logic                          last_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            results_o
);
  import usfp_pkg::*;

  // frame layout: first byte position, length and kind of every field
  localparam int unsigned FIELD_FIRST [FIELD_COUNT] = '{
    1, 7, 13, 19, 24, 30, 36, 42, 47, 51, 55, 59, 65, 71, 76, 82, 86, 87, 89, 98, 107, 108
  };
  localparam int unsigned FIELD_LEN [FIELD_COUNT] = '{
    5, 5, 5, 4, 5, 5, 5, 4, 3, 3, 3, 5, 5, 4, 5, 3, 1, 1, 8, 8, 1, 1
  };
  localparam kind_e FIELD_KIND [FIELD_COUNT] = '{
    KIND_TENTHS, KIND_TENTHS, KIND_TENTHS, KIND_TENTHS, KIND_TENTHS, KIND_TENTHS,
    KIND_TENTHS, KIND_TENTHS, KIND_INT, KIND_INT, KIND_INT, KIND_TENTHS, KIND_TENTHS,
    KIND_TENTHS, KIND_INT, KIND_INT, KIND_RAW, KIND_RAW, KIND_CODE, KIND_CODE,
    KIND_FLAG, KIND_FLAG
  };

  logic [POS_W-1:0]   pos_q;
  logic [ACC_W-1:0]   acc_q;
  logic               point_q;
  logic [FRAC_W-1:0]  frac_q;
  logic               stopped_q;
  logic               started_q;
  logic [VALUE_W-1:0] code_q;
  logic               idle_q;

  result_t expected_fields [$];
  int      mismatch_count;
  int      results_seen;

  assign mismatches_o = mismatch_count;
  assign results_o    = results_seen;

  task automatic report_mismatch(input string msg);
    $display("%0t: result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic expect_field(input logic [ID_W-1:0] id, input logic [VALUE_W-1:0] value,
                              input status_e st, input logic fin);
    result_t r;
    r.id     = id;
    r.value  = value;
    r.status = st;
    r.last   = fin;
    expected_fields.push_back(r);
  endtask

  // one accepted byte through the frame walker
  task automatic step_parser(input logic [BYTE_W-1:0] c, input logic start);
    int                 fld;
    kind_e              knd;
    logic               blank;
    logic [VALUE_W-1:0] v;
    if (start) begin
      pos_q  = '0;
      idle_q = 1'b0;
    end else if (idle_q) begin
      return;
    end
    if (pos_q == '0) begin
      if (c != HEADER_BYTE) begin
        idle_q = 1'b1;
        expect_field(END_ID, '0, ST_NO_HEADER, 1'b1);
      end else begin
        pos_q = POS_W'(1);
      end
      return;
    end
    if (pos_q >= END_POS) begin
      idle_q = 1'b1;
      pos_q  = '0;
      expect_field(END_ID, '0, (c == CR_BYTE) ? ST_OK : ST_NO_CR, 1'b1);
      return;
    end
    fld = -1;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (pos_q >= FIELD_FIRST[i] && pos_q < FIELD_FIRST[i] + FIELD_LEN[i]) fld = i;
    end
    if (fld < 0) begin
      pos_q++;
      return;
    end
    knd = FIELD_KIND[fld];
    if (pos_q == FIELD_FIRST[fld]) begin
      acc_q     = '0;
      point_q   = 1'b0;
      frac_q    = '0;
      stopped_q = 1'b0;
      started_q = 1'b0;
      code_q    = '0;
    end
    if (knd == KIND_CODE) begin
      code_q = {code_q[VALUE_W-BYTE_W-1:0], c};
    end else if (knd == KIND_TENTHS || knd == KIND_INT) begin
      blank = (c == SPACE_BYTE) || (c >= 8'h09 && c <= 8'h0D);
      if (!stopped_q && !(blank && !started_q)) begin
        if (c >= ZERO_CHAR && c <= ZERO_CHAR + 8'd9) begin
          started_q = 1'b1;
          // only the first fraction digit counts, the rest are just tallied
          if (!point_q || frac_q == '0) acc_q = acc_q * ACC_W'(10) + ACC_W'(c - ZERO_CHAR);
          if (point_q && frac_q != FRAC_MAX) frac_q = frac_q + FRAC_W'(1);
        end else if (c == POINT_BYTE && knd == KIND_TENTHS && !point_q) begin
          point_q   = 1'b1;
          started_q = 1'b1;
        end else begin
          stopped_q = 1'b1;
        end
      end
    end
    if (pos_q == FIELD_FIRST[fld] + FIELD_LEN[fld] - 1) begin
      case (knd)
        KIND_TENTHS: v = (frac_q == '0) ? VALUE_W'(acc_q) * 10 : VALUE_W'(acc_q);
        KIND_INT:    v = VALUE_W'(acc_q);
        KIND_RAW:    v = VALUE_W'(c);
        KIND_CODE:   v = code_q;
        default:     v = (c == FLAG_ONE) ? VALUE_W'(1) : '0;
      endcase
      expect_field(ID_W'(fld), v, ST_OK, 1'b0);
    end
    pos_q++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t exp_r;
    if (!rst_ni) begin
      pos_q          = '0;
      acc_q          = '0;
      point_q        = 1'b0;
      frac_q         = '0;
      stopped_q      = 1'b0;
      started_q      = 1'b0;
      code_q         = '0;
      idle_q         = 1'b1;
      mismatch_count = 0;
      results_seen   = 0;
      expected_fields.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_fields.size() == 0) begin
          report_mismatch($sformatf("result id %0d value %0h with nothing expected",
                                    field_id_i, field_value_i));
        end else begin
          exp_r = expected_fields.pop_front();
          if (field_id_i !== exp_r.id)
            report_mismatch($sformatf("field_id expected %0d got %0d", exp_r.id, field_id_i));
          if (field_value_i !== exp_r.value)
            report_mismatch($sformatf("field_value of id %0d expected %0h got %0h",
                                      exp_r.id, exp_r.value, field_value_i));
          if (status_i !== exp_r.status)
            report_mismatch($sformatf("status expected %0d got %0d", exp_r.status, status_i));
          if (last_i !== exp_r.last)
            report_mismatch($sformatf("last expected %0b got %0b", exp_r.last, last_i));
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) step_parser(rx_byte_i, frame_start_i);
      pending_o <= expected_fields.size();
    end
  end

endmodule

/* verif/ups_status_frame_parser_tb.sv */
`timescale 1ns / 100ps
// testbench top for the ups status frame parser: clock, reset, byte stimulus and verdict
// depends on usfp_pkg, ups_status_frame_parser and ups_status_frame_parser_checker
module ups_status_frame_parser_tb;
  import usfp_pkg::*;

  localparam int FRAME_LEN    = 110;
  localparam int ITEM_TARGET  = 1050;  // frame bytes to send in the random part
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, fills the pipeline
  localparam int DRAIN_CYCLES = 8;     // settle time after the last result has drained
  localparam int TIMEOUT_NS   = 5_000_000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [BYTE_W-1:0]  rx_byte;
  logic               frame_start;
  logic               out_valid;
  logic               out_stall;
  logic [ID_W-1:0]    field_id;
  logic [VALUE_W-1:0] field_value;
  logic [STATUS_W-1:0] status;
  logic               res_last;

  int mismatches;
  int pending;
  int results;

  // stimulus bookkeeping
  logic [BYTE_W-1:0] frame_buf [FRAME_LEN];
  logic calm = 1'b0;        // no random idling on either side while set
  int   holds_requested = 0;
  int   holds_done = 0;
  int   frame_requests = 0;
  int   full_frames = 0;
  int   cut_frames = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ups_status_frame_parser DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .field_id_o    (field_id),
    .field_value_o (field_value),
    .status_o      (status),
    .last_o        (res_last)
  );

  ups_status_frame_parser_checker result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .rx_byte_i     (rx_byte),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .field_id_i    (field_id),
    .field_value_i (field_value),
    .status_i      (status),
    .last_i        (res_last),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .results_o     (results)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one byte request; valid stays high across back-to-back requests
  task automatic send_request(input logic [BYTE_W-1:0] b, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender pause until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // random but mostly well-formed reply in frame_buf
  task automatic fill_frame();
    int    first;
    int    len;
    int    lead;
    int    r;
    kind_e knd;
    // separators: mostly spaces, sometimes junk
    for (int p = 0; p < FRAME_LEN; p++)
      frame_buf[p] = ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom) : SPACE_BYTE;
    frame_buf[0]       = ($urandom_range(0, 19) == 0) ? BYTE_W'($urandom) : HEADER_BYTE;
    frame_buf[END_POS] = ($urandom_range(0, 6) == 0) ? BYTE_W'($urandom) : CR_BYTE;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      first = FIELD_TBL[f].first;
      len   = FIELD_TBL[f].last - FIELD_TBL[f].first + 1;
      knd   = FIELD_TBL[f].kind;
      case (knd)
        KIND_TENTHS, KIND_INT: begin
          r = $urandom_range(0, 9);
          // now and then all junk or all blanks (zero), otherwise a few leading blanks then mostly digits
          lead = (r == 1) ? len : $urandom_range(0, 2);
          for (int p = 0; p < len; p++) begin
            if (r == 0) begin
              frame_buf[first + p] = BYTE_W'($urandom);
            end else if (p < lead) begin
              frame_buf[first + p] = ($urandom_range(0, 2) == 0) ?
                                     BYTE_W'(8'h09 + $urandom_range(0, 4)) : SPACE_BYTE;
            end else begin
              r = $urandom_range(1, 99);
              if (r < 80)      frame_buf[first + p] = ZERO_CHAR + BYTE_W'($urandom_range(0, 9));
              else if (r < 90) frame_buf[first + p] = POINT_BYTE;
              else if (r < 95) frame_buf[first + p] = BYTE_W'($urandom);
              else             frame_buf[first + p] = ($urandom_range(0, 1) != 0) ? "-" : " ";
            end
          end
        end
        KIND_CODE: begin
          for (int p = 0; p < len; p++)
            frame_buf[first + p] = ($urandom_range(0, 9) < 7) ?
                                   ZERO_CHAR + BYTE_W'($urandom_range(0, 1)) : BYTE_W'($urandom);
        end
        KIND_FLAG: begin
          r = $urandom_range(0, 9);
          frame_buf[first] = (r < 5) ? FLAG_ONE : (r < 8) ? ZERO_CHAR : BYTE_W'($urandom);
        end
        default: begin
          frame_buf[first] = ($urandom_range(0, 1) != 0) ?
                             ZERO_CHAR + BYTE_W'($urandom_range(0, 9)) : BYTE_W'($urandom);
        end
      endcase
    end
  endtask

  // first count bytes of frame_buf; after a bad header the rest would only be ignored
  task automatic send_frame(input int count);
    int n;
    n = (frame_buf[0] == HEADER_BYTE) ? count : 1;
    for (int p = 0; p < n; p++) send_request(frame_buf[p], p == 0);
    frame_requests += n;
  endtask

  // receiver: random stalls, a long hold-off whenever the stimulus asks for one
  initial begin : receiver
    int   span;
    logic hold;
    forever begin
      if (holds_done != holds_requested) begin
        hold = 1'b1;
        span = HOLD_CYCLES;
        holds_done++;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        hold = 1'b1;
        span = pick_gap() + 1;
      end else begin
        hold = 1'b0;
        span = $urandom_range(1, 10);
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    string directed;
    int    sel;
    int    frame_no;
    in_valid    <= 1'b0;
    rx_byte     <= '0;
    frame_start <= 1'b0;
    rst_n       <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored byte before any frame, bad header, then the first fields with
    // leading white space and a point, five digits without point, a second point,
    // and a sign that stops the number; the next frame start cuts this frame short
    send_request(8'hFF, 1'b0);
    send_request(8'hA5, 1'b1);
    directed = "(\t 1.2 99999 9.9.9 -1.5";
    for (int i = 0; i < directed.len(); i++) send_request(directed[i], i == 0);
    wait_drained();

    // random frames: mostly whole, some cut short by the next frame start, some noise
    frame_no = 0;
    while (frame_requests < ITEM_TARGET) begin
      frame_no++;
      // long receiver hold-off while bytes keep coming
      if (frame_no == 3 || frame_no == 7) holds_requested++;
      if (frame_no % 4 == 0) wait_drained();
      calm = ($urandom_range(0, 7) == 0);
      fill_frame();
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        send_frame(FRAME_LEN);
        full_frames++;
      end else if (sel < 90) begin
        send_frame($urandom_range(1, FRAME_LEN - 1));
        cut_frames++;
      end else begin
        // bytes without a frame start: ignored while idle, continue a cut frame otherwise
        repeat ($urandom_range(1, 4)) send_request(BYTE_W'($urandom), 1'b0);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d frame byte requests: %0d whole frames, %0d cut short, plus noise",
             frame_requests, full_frames, cut_frames);
    $display("%0d result requests compared, %0d long receiver hold-offs", results, holds_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("timeout with %0d results still outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
